// ===== sv/voxel_face_culling_extractor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel face culling extractor assertion macros
// Shared property forms for the concurrent checks of the extractor top level.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_EXTRACTOR_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULLING_EXTRACTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vfce_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling extractor package
// Types, codes and the face corner table shared by the extractor modules.
// ----------------------------------------------------------------------------
package vfce_pkg;

    localparam int VFCE_MAX_DIM = 32;
    localparam int FUNC_W       = 2;
    localparam int COORD_W      = 5;
    localparam int SIZE_W       = 6;
    localparam int EXT_W        = 7;
    localparam int CNT_W        = 20;
    localparam int DIR_W        = 3;
    localparam int CORNER_W     = 3;
    localparam int NUM_DIRS     = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int RD_IDX_W     = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
    localparam logic [CNT_W-1:0]  CNT_STEP   = CNT_W'(4);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } t_cfg_reg;

    typedef enum logic [DIR_W-1:0] {
        DIR_NX = 3'd0,
        DIR_PX = 3'd1,
        DIR_NY = 3'd2,
        DIR_PY = 3'd3,
        DIR_NZ = 3'd4,
        DIR_PZ = 3'd5
    } t_dir;

    // Row reads of one query: the voxel's own row, then its four side rows.
    typedef enum logic [RD_IDX_W-1:0] {
        RD_CENTER = 3'd0,
        RD_XM     = 3'd1,
        RD_XP     = 3'd2,
        RD_YM     = 3'd3,
        RD_YP     = 3'd4
    } t_rd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WR_RD,
        S_WR_WR,
        S_LOOK,
        S_LOOK_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] vox_x;
        logic [COORD_W-1:0] vox_y;
        logic [COORD_W-1:0] vox_z;
        logic               active_in;
    } t_in;

    typedef struct packed {
        logic                face_valid;
        logic [DIR_W-1:0]    face_dir;
        logic [CNT_W-1:0]    base_vertex;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic                last;
    } t_out;

    typedef struct packed {
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
        logic [CORNER_W-1:0] d;
    } t_corners;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic rd_capture;
        logic wr_row;
        logic clr_step;
        logic cnt_clear;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              in_grid;
        logic              rd_last;
        logic              clr_done;
        logic              emit_last;
    } t_dp_status;

    function automatic t_corners corner_of(input t_dir dir);
        t_corners c;
        unique case (dir)
            DIR_NX:  c = '{a: 3'd4, b: 3'd5, c: 3'd1, d: 3'd0};
            DIR_PX:  c = '{a: 3'd3, b: 3'd2, c: 3'd6, d: 3'd7};
            DIR_NY:  c = '{a: 3'd4, b: 3'd0, c: 3'd3, d: 3'd7};
            DIR_PY:  c = '{a: 3'd1, b: 3'd5, c: 3'd6, d: 3'd2};
            DIR_NZ:  c = '{a: 3'd0, b: 3'd1, c: 3'd2, d: 3'd3};
            DIR_PZ:  c = '{a: 3'd7, b: 3'd6, c: 3'd5, d: 3'd4};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/vfce_occ_mem.sv =====
// ----------------------------------------------------------------------------
// Occupancy row memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vfce_occ_mem #(
    parameter int ROW_AW = 10,
    parameter int WORD_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_AW-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ROW_AW-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [1 << ROW_AW];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

// ===== sv/vfce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Extractor controller
// Sequences the clearing pass, voxel writes, row reads and face beats.
// ----------------------------------------------------------------------------
module vfce_ctrl import vfce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.func)
                    FUNC_WRITE: n_state = i_status.in_grid ? S_WR_RD : S_IDLE;
                    FUNC_QUERY: n_state = S_LOOK;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_WR_RD:     n_state = S_WR_WR;
            S_WR_WR:     n_state = S_IDLE;
            S_LOOK: begin
                if (i_status.rd_last) begin
                    n_state = S_LOOK_WAIT;
                end
            end
            S_LOOK_WAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_step  = 1'b1;
            S_IDLE:   o_cmd.accept    = i_start;
            S_DECODE: o_cmd.cnt_clear = (i_status.func == FUNC_CLEAR);
            S_WR_RD:  o_cmd.rd_issue  = 1'b1;
            S_WR_WR:  o_cmd.wr_row    = 1'b1;
            S_LOOK: begin
                o_cmd.rd_issue   = 1'b1;
                o_cmd.rd_capture = 1'b1;
            end
            S_EMIT:   o_cmd.emit      = 1'b1;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

// ===== sv/vfce_datapath.sv =====
// ----------------------------------------------------------------------------
// Extractor datapath
// Holds the size registers, the vertex counter, the occupancy memory and the
// face mask built from the row reads, and drives the result register.
// ----------------------------------------------------------------------------
module vfce_datapath import vfce_pkg::*; #(
    parameter int MAX_DIM = VFCE_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    input  t_in                  i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    output t_dp_status           o_status,
    output logic                 o_strobe,
    output t_out                 o_result
);

    localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int WORD_W = 1 << AW;
    localparam int ROW_AW = 2 * AW;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

    // Sizes of zero act as one and sizes above the grid act as the grid.
    function automatic logic [EXT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [EXT_W-1:0] se;
        se = {1'b0, s};
        if (s == '0) begin
            return EXT_W'(1);
        end else if (se > MAX_EXT) begin
            return MAX_EXT;
        end
        return se;
    endfunction

    logic [SIZE_W-1:0]   r_size_x, r_size_y, r_size_z;
    logic [FUNC_W-1:0]   r_func;
    logic [COORD_W-1:0]  r_x, r_y, r_z;
    logic                r_active_in;
    t_rd                 r_rd_idx;
    logic                r_cap_valid;
    t_rd                 r_cap_idx;
    logic                r_active;
    logic [NUM_DIRS-1:0] r_vis;
    logic [NUM_DIRS-1:0] n_vis;
    logic [CNT_W-1:0]    r_vcount;
    logic [CNT_W-1:0]    n_vcount;
    logic [ROW_AW-1:0]   r_clr_addr;
    logic                r_strobe;
    t_out                r_result;
    t_out                n_result;

    logic [EXT_W-1:0]    ex, ey, ez;
    logic [EXT_W-1:0]    xe, ye, ze, xm, xp, ym, yp, zm, zp;
    logic                vox_in_grid;
    logic [EXT_W-1:0]    rd_x, rd_y;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   wr_word;
    logic [ROW_AW-1:0]   wr_addr;
    logic                mem_we;
    logic [NUM_DIRS-1:0] mask;
    logic [NUM_DIRS-1:0] mask_rest;
    t_dir                low_dir;
    t_corners            corners;

    assign ex = eff_size(r_size_x);
    assign ey = eff_size(r_size_y);
    assign ez = eff_size(r_size_z);
    assign xe = {2'b00, r_x};
    assign ye = {2'b00, r_y};
    assign ze = {2'b00, r_z};
    assign xm = xe - EXT_W'(1);
    assign xp = xe + EXT_W'(1);
    assign ym = ye - EXT_W'(1);
    assign yp = ye + EXT_W'(1);
    assign zm = ze - EXT_W'(1);
    assign zp = ze + EXT_W'(1);
    assign vox_in_grid = (xe < ex) && (ye < ey) && (ze < ez);

    // Side rows that fall off the grid are still read; the edge tests
    // below keep their contents out of the face mask.
    always_comb begin
        rd_x = xe;
        rd_y = ye;
        unique case (r_rd_idx)
            RD_CENTER: ;
            RD_XM:     rd_x = xm;
            RD_XP:     rd_x = xp;
            RD_YM:     rd_y = ym;
            RD_YP:     rd_y = yp;
            default:   ;
        endcase
    end

    always_comb begin
        wr_word = rd_word;
        wr_word[ze[AW-1:0]] = r_active_in;
        wr_addr = {xe[AW-1:0], ye[AW-1:0]};
        mem_we  = i_cmd.wr_row;
        if (i_cmd.clr_step) begin
            wr_word = '0;
            wr_addr = r_clr_addr;
            mem_we  = 1'b1;
        end
    end

    vfce_occ_mem #(
        .ROW_AW (ROW_AW),
        .WORD_W (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_re    (i_cmd.rd_issue),
        .i_raddr ({rd_x[AW-1:0], rd_y[AW-1:0]}),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func      <= i_item.func;
            r_x         <= i_item.vox_x;
            r_y         <= i_item.vox_y;
            r_z         <= i_item.vox_z;
            r_active_in <= i_item.active_in;
            r_rd_idx    <= RD_CENTER;
        end else if (i_cmd.rd_issue) begin
            r_rd_idx    <= t_rd'(r_rd_idx + RD_IDX_W'(1));
        end
        r_cap_idx <= r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_valid <= 1'b0;
            r_clr_addr  <= '0;
            r_vcount    <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_cap_valid <= i_cmd.rd_capture;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ROW_AW'(1);
            end
            r_vcount <= n_vcount;
            r_strobe <= i_cmd.emit;
        end
    end

    // Each returning row settles the faces that look into it.
    always_comb begin
        n_vis = r_vis;
        if (r_cap_valid) begin
            unique case (r_cap_idx)
                RD_CENTER: begin
                    n_vis[DIR_NZ] = !((r_z != '0) && rd_word[zm[AW-1:0]]);
                    n_vis[DIR_PZ] = !((zp < ez) && rd_word[zp[AW-1:0]]);
                end
                RD_XM: n_vis[DIR_NX] = !((r_x != '0) && rd_word[ze[AW-1:0]]);
                RD_XP: n_vis[DIR_PX] = !((xp < ex) && rd_word[ze[AW-1:0]]);
                RD_YM: n_vis[DIR_NY] = !((r_y != '0) && rd_word[ze[AW-1:0]]);
                RD_YP: n_vis[DIR_PY] = !((yp < ey) && rd_word[ze[AW-1:0]]);
                default: ;
            endcase
        end else if (i_cmd.emit) begin
            n_vis = mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis <= n_vis;
        if (r_cap_valid && (r_cap_idx == RD_CENTER)) begin
            r_active <= vox_in_grid && rd_word[ze[AW-1:0]];
        end
    end

    assign mask = r_active ? r_vis : '0;

    always_comb begin
        low_dir = DIR_NX;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                low_dir = t_dir'(DIR_W'(i));
            end
        end
    end

    assign mask_rest = mask & ~(NUM_DIRS'(1) << low_dir);
    assign corners   = corner_of(low_dir);

    always_comb begin
        n_vcount = r_vcount;
        n_result = r_result;
        if (i_cmd.cnt_clear) begin
            n_vcount = '0;
        end else if (i_cmd.emit) begin
            if (mask == '0) begin
                n_result      = '0;
                n_result.last = 1'b1;
            end else begin
                n_result.face_valid  = 1'b1;
                n_result.face_dir    = low_dir;
                n_result.base_vertex = r_vcount;
                n_result.corner_a    = corners.a;
                n_result.corner_b    = corners.b;
                n_result.corner_c    = corners.c;
                n_result.corner_d    = corners.d;
                n_result.last        = (mask_rest == '0);
                n_vcount             = r_vcount + CNT_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_status.func      = r_func;
    assign o_status.in_grid   = vox_in_grid;
    assign o_status.rd_last   = (r_rd_idx == RD_YP);
    assign o_status.clr_done  = (r_clr_addr == '1);
    assign o_status.emit_last = (mask_rest == '0);
    assign o_strobe           = r_strobe;
    assign o_result           = r_result;

endmodule

// ===== sv/voxel_face_culling_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling extractor
// Bit grid of active voxels with hidden-face culling and a vertex counter.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the occupancy memory and
// holds busy high until the pass ends; configuration writes are taken during
// that pass as at any time. A command beat is taken on a rising edge with
// start high and busy low. A voxel write inside the grid keeps busy high
// through decode, row read and row write; a write outside the grid, a counter
// clear or an unused code keeps it high for the decode only. A face query
// keeps busy high through decode, the row reads, a wait state and the issue
// of its result beats (one to six): the occupancy memory has a single read
// port and the query reads five rows of it, the voxel's own row (which also
// carries its two z neighbors) and the four side rows, one per cycle, before
// the first face goes out. Result beats then follow on consecutive cycles,
// one cycle each with o_strobe high; the receiver must take every beat as it
// comes, since nothing here can hold a result back. The last beat of a query
// has last set, and a query with no visible face gives a single beat with
// face_valid low and all other fields zero apart from last.
// ----------------------------------------------------------------------------
`include "voxel_face_culling_extractor_unit_defines.svh"

module voxel_face_culling_extractor_unit import vfce_pkg::*; #(
    parameter int MAX_DIM = VFCE_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in                  i_cmd,
    output logic                 o_strobe,
    output t_out                 o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    // Commands from the controller to the datapath and status back.
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    vfce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_cmd    (ctrl_cmd)
    );

    // The datapath owns the occupancy memory, sizes and vertex counter.
    vfce_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .i_item     (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (dp_status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // An empty query answer is a single closing beat with zeroed fields.
    `VFCE_ASSERT_NOW(a_empty_beat_closes, i_clk, i_rst_n, o_strobe && !o_result.face_valid, o_result.last && o_result.base_vertex == '0 && o_result.face_dir == '0, "empty result beat is not a zeroed last beat")

    // Result beats only come out of work that was still in progress.
    `VFCE_ASSERT_NOW(a_beat_from_busy, i_clk, i_rst_n, o_strobe, $past(busy), "result beat while the block was idle")

    // The cycle after a command is taken is spent decoding it.
    `VFCE_ASSERT_NEXT(a_no_beat_after_accept, i_clk, i_rst_n, start && !busy, !o_strobe && busy, "result beat or idle right after a command")

endmodule

// ===== dv/voxel_face_culling_extractor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling extractor testbench
// Drives write, query, clear and unused commands through the start/busy port,
// mirrors the occupancy grid, extents and vertex counter in a local model, and
// checks every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module voxel_face_culling_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfce_pkg::*;

    // Function code 3 has no package name; the block must ignore it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // The slowest correct run is about 44 us: some 414 commands, each after
    // its longest random gap and at worst a six-face query, plus the clearing
    // pass and the settling between phases. Allow about four and a half times
    // that.
    localparam int TIMEOUT_NS = 200_000;

    // Neighbor offsets and face corners, indexed by face direction.
    localparam int STEP_X [6] = '{-1, 1, 0, 0, 0, 0};
    localparam int STEP_Y [6] = '{0, 0, -1, 1, 0, 0};
    localparam int STEP_Z [6] = '{0, 0, 0, 0, -1, 1};
    localparam logic [CORNER_W-1:0] FACE_CORNERS [6][4] = '{
        '{3'd4, 3'd5, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd6, 3'd7},
        '{3'd4, 3'd0, 3'd3, 3'd7},
        '{3'd1, 3'd5, 3'd6, 3'd2},
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd7, 3'd6, 3'd5, 3'd4}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_in                  i_cmd      = '0;
    logic                 o_strobe;
    t_out                 o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_SIZE_X;
    logic [SIZE_W-1:0]    i_cfg_data = '0;

    // Local copy of the block state. The grid starts all clear, the extents at
    // their reset value of 32 and the vertex counter at zero.
    bit                grid_bits [VFCE_MAX_DIM * VFCE_MAX_DIM * VFCE_MAX_DIM];
    logic [SIZE_W-1:0] ext_x      = SIZE_RESET;
    logic [SIZE_W-1:0] ext_y      = SIZE_RESET;
    logic [SIZE_W-1:0] ext_z      = SIZE_RESET;
    logic [CNT_W-1:0]  vert_count = '0;

    // Result beats still owed by the block, oldest first.
    t_out expected_faces [$];

    int mismatch_count = 0;
    bit idle_on        = 1'b1;

    voxel_face_culling_extractor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A size register of zero behaves as one, anything above the grid maximum
    // behaves as the maximum.
    function automatic int clamp_extent(input logic [SIZE_W-1:0] s);
        if (s == '0) return 1;
        if (int'(s) > VFCE_MAX_DIM) return VFCE_MAX_DIM;
        return int'(s);
    endfunction

    function automatic bit in_grid(input int x, input int y, input int z);
        return x >= 0 && y >= 0 && z >= 0 && x < clamp_extent(ext_x)
            && y < clamp_extent(ext_y) && z < clamp_extent(ext_z);
    endfunction

    function automatic int grid_index(input int x, input int y, input int z);
        return (x * VFCE_MAX_DIM + y) * VFCE_MAX_DIM + z;
    endfunction

    // Anything outside the current grid reads as an empty voxel.
    function automatic bit voxel_set(input int x, input int y, input int z);
        if (!in_grid(x, y, z)) return 1'b0;
        return grid_bits[grid_index(x, y, z)];
    endfunction

    // Applies one accepted command beat to the model and queues the result
    // beats that it owes.
    task automatic predict_command(input t_in c);
        t_out faces [$];
        t_out beat;
        int   x;
        int   y;
        int   z;
        x = int'(c.vox_x);
        y = int'(c.vox_y);
        z = int'(c.vox_z);
        case (c.func)
            FUNC_WRITE: begin
                // A write outside the grid is dropped.
                if (in_grid(x, y, z)) grid_bits[grid_index(x, y, z)] = c.active_in;
            end
            FUNC_CLEAR: begin
                vert_count = '0;
            end
            FUNC_QUERY: begin
                if (voxel_set(x, y, z)) begin
                    for (int d = DIR_NX; d <= DIR_PZ; d++) begin
                        if (!voxel_set(x + STEP_X[d], y + STEP_Y[d], z + STEP_Z[d])) begin
                            beat             = '0;
                            beat.face_valid  = 1'b1;
                            beat.face_dir    = DIR_W'(d);
                            beat.base_vertex = vert_count;
                            beat.corner_a    = FACE_CORNERS[d][0];
                            beat.corner_b    = FACE_CORNERS[d][1];
                            beat.corner_c    = FACE_CORNERS[d][2];
                            beat.corner_d    = FACE_CORNERS[d][3];
                            faces = {faces, beat};
                            // The counter wraps naturally at its 20-bit width.
                            vert_count += CNT_STEP;
                        end
                    end
                end
                // An empty, outside or fully enclosed voxel still answers with
                // one beat that carries nothing but last.
                if (faces.size() == 0) begin
                    beat      = '0;
                    beat.last = 1'b1;
                    faces = {faces, beat};
                end else begin
                    faces[faces.size() - 1].last = 1'b1;
                end
                expected_faces = {expected_faces, faces};
            end
            default: begin
                // The unused code changes nothing and owes nothing.
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Every strobed beat is taken at the edge that ends its cycle, since the
    // block cannot be held off. Values read here are the ones from before the
    // edge, so the sample never races the block's own updates.
    always @(posedge i_clk) begin : check_beats
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_faces.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %p", o_result));
            end else begin
                want = expected_faces.pop_front();
                check_field("face_valid", o_result.face_valid, want.face_valid);
                check_field("face_dir", o_result.face_dir, want.face_dir);
                check_field("base_vertex", o_result.base_vertex, want.base_vertex);
                check_field("corner_a", o_result.corner_a, want.corner_a);
                check_field("corner_b", o_result.corner_b, want.corner_b);
                check_field("corner_c", o_result.corner_c, want.corner_c);
                check_field("corner_d", o_result.corner_d, want.corner_d);
                check_field("last", o_result.last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    function automatic t_in make_cmd(input logic [FUNC_W-1:0] f, input int x, input int y,
                                     input int z, input bit active);
        t_in c;
        c.func      = f;
        c.vox_x     = COORD_W'(x);
        c.vox_y     = COORD_W'(y);
        c.vox_z     = COORD_W'(z);
        c.active_in = active;
        return c;
    endfunction

    // Sends one command beat. Start stays high after acceptance and is only
    // touched again at the next falling edge: either by the next beat, which
    // keeps it high when it draws no gap, or by settle_block. The block is busy
    // right after an accept, so the stale command cannot be taken twice.
    task automatic send_command(input t_in c);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predict_command(c);
    endtask

    // Drops start, waits for every owed beat, then lets the block finish any
    // write or clear that owes none.
    task automatic settle_block();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_faces.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_extent(input t_cfg_reg which, input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (which)
            CFG_SIZE_X: ext_x = value;
            CFG_SIZE_Y: ext_y = value;
            CFG_SIZE_Z: ext_z = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_extents(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                               input logic [SIZE_W-1:0] sz);
        write_extent(CFG_SIZE_X, sx);
        write_extent(CFG_SIZE_Y, sy);
        write_extent(CFG_SIZE_Z, sz);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Full 32-cube grid from reset: every command code, grid corners, partial
    // culling, a fully enclosed voxel and a voxel cleared again.
    task automatic test_directed();
        send_command(make_cmd(FUNC_QUERY, 0, 0, 0, 1'b0));      // empty voxel
        send_command(make_cmd(FUNC_WRITE, 0, 0, 0, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 0, 0, 0, 1'b0));      // all six faces
        send_command(make_cmd(FUNC_WRITE, 1, 0, 0, 1'b1));
        send_command(make_cmd(FUNC_WRITE, 0, 1, 0, 1'b1));
        send_command(make_cmd(FUNC_WRITE, 0, 0, 1, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 0, 0, 0, 1'b1));      // only the minus faces
        send_command(make_cmd(FUNC_QUERY, 1, 0, 0, 1'b0));
        send_command(make_cmd(FUNC_WRITE, 31, 31, 31, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 31, 31, 31, 1'b1));   // far grid corner
        send_command(make_cmd(FUNC_CLEAR, 31, 31, 31, 1'b1));
        send_command(make_cmd(FUNC_UNUSED, 31, 31, 31, 1'b1));
        // Enclose voxel (2,2,2) on all six sides.
        send_command(make_cmd(FUNC_WRITE, 2, 2, 2, 1'b1));
        for (int d = DIR_NX; d <= DIR_PZ; d++) begin
            send_command(make_cmd(FUNC_WRITE, 2 + STEP_X[d], 2 + STEP_Y[d],
                                  2 + STEP_Z[d], 1'b1));
        end
        send_command(make_cmd(FUNC_QUERY, 2, 2, 2, 1'b0));
        send_command(make_cmd(FUNC_QUERY, 2, 2, 1, 1'b0));      // hidden on +z only
        send_command(make_cmd(FUNC_WRITE, 2, 2, 2, 1'b0));
        send_command(make_cmd(FUNC_QUERY, 2, 2, 2, 1'b0));
        send_command(make_cmd(FUNC_QUERY, 2, 2, 1, 1'b0));
    endtask

    // Size registers at and beyond their limits, writes and queries outside
    // the grid, and faces on the boundary of a shrunken grid.
    task automatic test_extents();
        settle_block();
        set_extents(6'd0, 6'd63, 6'd33);                        // acts as 1 x 32 x 32
        send_command(make_cmd(FUNC_WRITE, 1, 3, 3, 1'b1));      // outside, dropped
        send_command(make_cmd(FUNC_QUERY, 1, 3, 3, 1'b0));
        send_command(make_cmd(FUNC_WRITE, 0, 3, 3, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 0, 3, 3, 1'b0));
        send_command(make_cmd(FUNC_WRITE, 0, 3, 4, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 0, 3, 3, 1'b0));
        settle_block();
        set_extents(6'd3, 6'd2, 6'd1);
        send_command(make_cmd(FUNC_WRITE, 2, 1, 0, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 2, 1, 0, 1'b0));
        send_command(make_cmd(FUNC_WRITE, 3, 0, 0, 1'b1));      // outside, dropped
        send_command(make_cmd(FUNC_QUERY, 3, 0, 0, 1'b0));
        send_command(make_cmd(FUNC_WRITE, 1, 1, 0, 1'b1));
        send_command(make_cmd(FUNC_QUERY, 2, 1, 0, 1'b0));
        // Growing x and z again while shrinking y to one leaves the neighbor written at (1,1,0) outside the grid.
        settle_block();
        set_extents(6'd32, 6'd1, 6'd32);
        send_command(make_cmd(FUNC_QUERY, 1, 0, 0, 1'b0));
    endtask

    // Random phases, each under its own grid size. Coordinates are drawn from
    // a small cluster so that neighbors are often occupied and culling is
    // exercised; a few are drawn from the whole coordinate range.
    task automatic test_random_mix();
        logic [SIZE_W-1:0] sz [3];
        int                lo [3];
        int                span [3];
        int                crd [3];
        int unsigned       pick;
        logic [FUNC_W-1:0] f;
        bit                active;
        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            for (int d = 0; d < 3; d++) begin
                if (phase == 0) begin
                    sz[d] = 6'd32;
                end else begin
                    case ($urandom_range(0, 7))
                        0:       sz[d] = 6'd0;
                        1:       sz[d] = 6'd63;
                        2:       sz[d] = 6'd33;
                        3:       sz[d] = 6'd32;
                        default: sz[d] = SIZE_W'($urandom_range(1, 6));
                    endcase
                end
                // Small grids are covered whole plus one step past the edge.
                if (clamp_extent(sz[d]) >= 8) begin
                    lo[d]   = $urandom_range(0, 31);
                    span[d] = 3;
                end else begin
                    lo[d]   = 0;
                    span[d] = clamp_extent(sz[d]);
                end
            end
            set_extents(sz[0], sz[1], sz[2]);
            // Phase 1 runs back to back; the others mostly with gaps.
            idle_on = (phase == 1) ? 1'b0 : (phase == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            repeat (60) begin
                pick   = $urandom_range(0, 99);
                active = 1'($urandom_range(0, 1));
                if (pick < 42) begin
                    f      = FUNC_WRITE;
                    active = ($urandom_range(0, 3) != 0);
                end else if (pick < 92) begin
                    f = FUNC_QUERY;
                end else if (pick < 97) begin
                    f = FUNC_CLEAR;
                end else begin
                    f = FUNC_UNUSED;
                end
                for (int d = 0; d < 3; d++) begin
                    crd[d] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                         : lo[d] + $urandom_range(0, span[d]);
                end
                send_command(make_cmd(f, crd[0], crd[1], crd[2], active));
            end
        end
    endtask

    // Runs one isolated voxel's six faces back to back so that the vertex
    // counter climbs by a full face set per query, with a clear before the first query and another in the middle.
    task automatic test_counter_run();
        settle_block();
        set_extents(6'd32, 6'd32, 6'd32);
        idle_on = 1'b0;
        for (int d = DIR_NX; d <= DIR_PZ; d++) begin
            send_command(make_cmd(FUNC_WRITE, 16 + STEP_X[d], 16 + STEP_Y[d],
                                  16 + STEP_Z[d], 1'b0));
        end
        send_command(make_cmd(FUNC_WRITE, 16, 16, 16, 1'b1));
        send_command(make_cmd(FUNC_CLEAR, 0, 0, 0, 1'b0));
        repeat (4) send_command(make_cmd(FUNC_QUERY, 16, 16, 16, 1'b0));
        send_command(make_cmd(FUNC_CLEAR, 0, 0, 0, 1'b0));
        repeat (4) send_command(make_cmd(FUNC_QUERY, 16, 16, 16, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    // Reset is held low from the start and released once. The block then runs its
    // clearing pass with busy high; the first command simply waits it out.
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_extents();
        test_random_mix();
        test_counter_run();
        settle_block();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // A hung handshake or a lost result beat ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/vfce_pkg.sv
sv/vfce_occ_mem.sv
sv/vfce_ctrl.sv
sv/vfce_datapath.sv
sv/voxel_face_culling_extractor_unit.sv
dv/voxel_face_culling_extractor_unit_tb.sv
